/* rtl/core/knn_majority_classifier_defines.svh */
// Assertion macros for the classifier RTL.
`ifndef KNN_MAJORITY_CLASSIFIER_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define KNN_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("knn check failed");
`define KNN_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knn check failed");
`else
`define KNN_ASSERT(name, cond)
`define KNN_ASSERT_IMPL(name, ante, cons)
`endif

`endif

/* rtl/core/knn_pkg.sv */
package knn_pkg;

    localparam int VAL_W = 17;
    localparam int SQ_W  = 2 * VAL_W;
    localparam logic [VAL_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        ACT_TRAIN = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_PREDICT = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [3:0]       bin_index;
        logic [VAL_W-1:0] bin_value;
        logic             label;
        logic             last;
    } knn_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       prediction;
        logic [1:0] vote_count;
    } knn_out_t;

    // Sideband that travels with each bin through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic label;
    } knn_tag_t;

endpackage

/* rtl/core/knn_stream_if.sv */
interface knn_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/knn_dist.sv */
module knn_dist #(
    parameter int DIST_W = 37
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  knn_pkg::knn_tag_t        tag_in,
    input  logic [knn_pkg::VAL_W-1:0] train_val,
    input  logic [knn_pkg::VAL_W-1:0] query_val,
    output knn_pkg::knn_tag_t        done,
    output logic [DIST_W-1:0]        dist_sum
);
    import knn_pkg::*;

    knn_tag_t         tag2_reg, tag3_reg, tag4_reg;
    logic [VAL_W-1:0] diff_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [DIST_W-1:0] acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_comb
    begin
        acc_next = (tag3_reg.first ? '0 : acc_reg) + DIST_W'(sq_reg);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= (train_val > query_val) ? train_val - query_val : query_val - train_val;
        sq_reg   <= diff_reg * diff_reg;
        if (tag3_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Report only the completed sum of an entry.
    always_comb
    begin
        done       = tag4_reg;
        done.valid = tag4_reg.valid & tag4_reg.last;
        dist_sum   = acc_reg;
    end
endmodule

/* rtl/core/knn_majority_classifier.sv */
// Bin items are taken one per cycle while idle and the result slot is free.
// The last bin of a query runs the classification: the distance pass streams
// all n*BIN_COUNT stored bins through the single read port of the training
// store, one bin a cycle, and then drains; the selection then makes
// min(n, K_NEAREST) passes over the neighbor memory, pass i scanning entries
// i+1 to n-1. No item is taken until that prediction is handed off.
`include "knn_majority_classifier_defines.svh"

module knn_majority_classifier #(
    parameter int MAX_ENTRIES = 256,
    parameter int BIN_COUNT   = 16,
    parameter int K_NEAREST   = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    knn_stream_if.sink   sample,
    knn_stream_if.source result
);
    import knn_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int QI_W   = $clog2(BIN_COUNT);
    localparam int TD     = MAX_ENTRIES * BIN_COUNT;
    localparam int TA_W   = $clog2(TD);
    localparam int TB_W   = $clog2(TD + 1);
    localparam int DIST_W = 33 + $clog2(BIN_COUNT);
    localparam int KW     = $clog2(K_NEAREST + 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DIST    = 8'b0000_0010,
        S_DRAIN   = 8'b0000_0100,
        S_SORT_RD = 8'b0000_1000,
        S_SORT_LD = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_SORT_END = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [VAL_W-1:0]  train_mem [TD];
    logic              label_mem [MAX_ENTRIES];
    logic [VAL_W-1:0]  query_mem [BIN_COUNT];
    logic [DIST_W:0]   nb_mem    [MAX_ENTRIES];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TB_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic [QI_W-1:0]   b_reg, b_next;
    logic [TA_W-1:0]   taddr_reg, taddr_next;
    logic [CNT_W-1:0]  wr_reg, wr_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  jd_reg, jd_next;
    logic [KW-1:0]     keff_reg, keff_next;
    logic [KW-1:0]     votes_reg, votes_next;
    logic [DIST_W:0]   cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    knn_out_t          out_reg, out_next;

    knn_in_t           item;
    logic              accept;
    logic              out_free;
    logic [VAL_W-1:0]  sat_val;
    logic              idx_ok;
    logic              full;

    logic              train_we;
    logic [TA_W-1:0]   train_waddr;
    logic              label_we;
    logic              query_we;
    logic [VAL_W-1:0]  train_rdata;
    logic [VAL_W-1:0]  query_rdata;
    logic              label_rdata;
    knn_tag_t          tag_next, tag1_reg;
    knn_tag_t          dist_done;
    logic [DIST_W-1:0] dist_val;

    logic              nb_we;
    logic [IDX_W-1:0]  nb_waddr;
    logic [DIST_W:0]   nb_wdata;
    logic [IDX_W-1:0]  nb_raddr;
    logic [DIST_W:0]   nb_rdata;

    assign item     = sample.data;
    assign out_free = !out_valid_reg || result.ready;
    assign sample.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    assign sat_val = (item.bin_value > ONE_Q16) ? ONE_Q16 : item.bin_value;
    assign idx_ok  = 32'(item.bin_index) < BIN_COUNT;
    assign full    = 32'(count_reg) >= MAX_ENTRIES;

    assign train_we    = accept && item.action == ACT_TRAIN && !full && idx_ok;
    assign train_waddr = base_reg[TA_W-1:0] + TA_W'(item.bin_index);
    assign label_we    = accept && item.action == ACT_TRAIN && item.last && !full;
    assign query_we    = accept && item.action == ACT_QUERY && idx_ok;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        e_next         = e_reg;
        b_next         = b_reg;
        taddr_next     = taddr_reg;
        wr_next        = wr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        keff_next      = keff_reg;
        votes_next     = votes_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        tag_next       = '0;
        nb_we          = 1'b0;
        nb_waddr       = wr_reg[IDX_W-1:0];
        nb_wdata       = {dist_done.label, dist_val};
        nb_raddr       = i_reg[IDX_W-1:0];

        // Store each finished distance in entry order.
        if (dist_done.valid)
        begin
            nb_we   = 1'b1;
            wr_next = wr_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_CLEAR:
                        begin
                            count_next     = '0;
                            base_next      = '0;
                            out_next       = '{ST_CLEARED, 1'b0, 2'd0};
                            out_valid_next = 1'b1;
                        end
                        ACT_TRAIN:
                        begin
                            if (item.last)
                            begin
                                out_valid_next = 1'b1;
                                if (full)
                                begin
                                    out_next = '{ST_FULL, 1'b0, 2'd0};
                                end
                                else
                                begin
                                    out_next   = '{ST_STORED, 1'b0, 2'd0};
                                    count_next = count_reg + 1'b1;
                                    base_next  = base_reg + TB_W'(BIN_COUNT);
                                end
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (item.last)
                            begin
                                keff_next  = (32'(count_reg) < K_NEAREST) ?
                                             KW'(count_reg) : KW'(K_NEAREST);
                                votes_next = '0;
                                e_next     = '0;
                                b_next     = '0;
                                taddr_next = '0;
                                wr_next    = '0;
                                i_next     = '0;
                                state_next = (count_reg == '0) ? S_OUT : S_DIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIST:
            begin
                tag_next   = '{1'b1, b_reg == '0, b_reg == QI_W'(BIN_COUNT - 1), 1'b0};
                taddr_next = taddr_reg + 1'b1;
                if (b_reg == QI_W'(BIN_COUNT - 1))
                begin
                    b_next = '0;
                    e_next = e_reg + 1'b1;
                    if (e_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (wr_reg == count_reg)
                begin
                    state_next = S_SORT_RD;
                end
            end
            S_SORT_RD:
            begin
                j_next     = i_reg + 1'b1;
                state_next = S_SORT_LD;
            end
            S_SORT_LD:
            begin
                cur_next = nb_rdata;
                if (j_reg < count_reg)
                begin
                    nb_raddr   = j_reg[IDX_W-1:0];
                    jd_next    = j_reg;
                    j_next     = j_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SCAN:
            begin
                // Swap: the smaller entry moves to the running minimum.
                if (nb_rdata[DIST_W-1:0] < cur_reg[DIST_W-1:0])
                begin
                    nb_we    = 1'b1;
                    nb_waddr = jd_reg[IDX_W-1:0];
                    nb_wdata = cur_reg;
                    cur_next = nb_rdata;
                end
                if (j_reg < count_reg)
                begin
                    nb_raddr = j_reg[IDX_W-1:0];
                    jd_next  = j_reg;
                    j_next   = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SORT_END:
            begin
                votes_next = votes_reg + KW'(cur_reg[DIST_W]);
                i_next     = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 < CNT_W'(keff_reg)) ? S_SORT_RD : S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next.status     = ST_PREDICT;
                    out_next.prediction = (keff_reg != '0) &&
                                          (votes_reg >= (keff_reg >> 1) + 1'b1);
                    out_next.vote_count = 2'(votes_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            e_reg         <= '0;
            b_reg         <= '0;
            taddr_reg     <= '0;
            wr_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            jd_reg        <= '0;
            keff_reg      <= '0;
            votes_reg     <= '0;
            out_valid_reg <= 1'b0;
            tag1_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            e_reg         <= e_next;
            b_reg         <= b_next;
            taddr_reg     <= taddr_next;
            wr_reg        <= wr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            jd_reg        <= jd_next;
            keff_reg      <= keff_next;
            votes_reg     <= votes_next;
            out_valid_reg <= out_valid_next;
            tag1_reg      <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Training store and labels: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (train_we)
        begin
            train_mem[train_waddr] <= sat_val;
        end
        train_rdata <= train_mem[taddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_mem[count_reg[IDX_W-1:0]] <= item.label;
        end
        label_rdata <= label_mem[e_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (query_we)
        begin
            query_mem[QI_W'(item.bin_index)] <= sat_val;
        end
        query_rdata <= query_mem[b_reg];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_rdata <= nb_mem[nb_raddr];
    end

    knn_tag_t tag1_lbl;
    always_comb
    begin
        tag1_lbl       = tag1_reg;
        tag1_lbl.label = label_rdata;
    end

    knn_dist #(
        .DIST_W (DIST_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag1_lbl),
        .train_val (train_rdata),
        .query_val (query_rdata),
        .done      (dist_done),
        .dist_sum  (dist_val)
    );

    `KNN_ASSERT(a_count_bound, 32'(count_reg) <= MAX_ENTRIES)
    `KNN_ASSERT_IMPL(a_ready_idle, sample.ready, state_reg == S_IDLE)
    `KNN_ASSERT_IMPL(a_swap_above_i, nb_we && state_reg == S_SCAN, jd_reg > i_reg)
    `KNN_ASSERT_IMPL(a_no_dist_in_sort, dist_done.valid,
                     state_reg == S_DIST || state_reg == S_DRAIN)
endmodule

/* tb/tb_knn_majority_classifier.sv */
module tb_knn_majority_classifier;
    import knn_pkg::*;

    localparam int SLOTS       = 256;
    localparam int BINS        = 16;
    localparam int NEIGHBORS   = 3;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;

    logic clk;
    logic rst_n;

    knn_stream_if #(.payload_t(knn_in_t))  sample_if ();
    knn_stream_if #(.payload_t(knn_out_t)) result_if ();

    knn_majority_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    // Shadow of the classifier state
    logic [16:0] train_bins [SLOTS][BINS];
    logic        train_lbl  [SLOTS];
    bit   [15:0] train_seen [SLOTS];
    int          entry_cnt;
    logic [16:0] query_bins [BINS];
    bit   [15:0] query_seen;

    knn_out_t    pending_q[$];
    int          error_cnt;
    int          items_sent;
    bit          calm;
    bit          hold_req;
    int          idle_cnt;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic classify_query(output knn_out_t res);
        longint unsigned sq_dist [SLOTS];
        logic            lbl  [SLOTS];
        longint unsigned d, td;
        logic            tl;
        int              keff;
        int              votes;
        begin
            votes = 0;
            for (int e = 0; e < entry_cnt; e++)
            begin
                sq_dist[e] = 0;
                for (int b = 0; b < BINS; b++)
                begin
                    d = (train_bins[e][b] > query_bins[b]) ?
                        train_bins[e][b] - query_bins[b] : query_bins[b] - train_bins[e][b];
                    sq_dist[e] += d * d;
                end
                lbl[e] = train_lbl[e];
            end
            keff = (entry_cnt < NEIGHBORS) ? entry_cnt : NEIGHBORS;
            for (int i = 0; i < keff; i++)
            begin
                for (int j = i + 1; j < entry_cnt; j++)
                begin
                    if (sq_dist[j] < sq_dist[i])
                    begin
                        td = sq_dist[i]; tl = lbl[i];
                        sq_dist[i] = sq_dist[j]; lbl[i] = lbl[j];
                        sq_dist[j] = td; lbl[j] = tl;
                    end
                end
            end
            for (int i = 0; i < keff; i++)
                votes += lbl[i];
            res.status     = ST_PREDICT;
            res.prediction = (keff > 0 && votes >= keff / 2 + 1);
            res.vote_count = votes[1:0];
        end
    endtask

    task automatic predict_item(input knn_in_t it);
        logic [16:0] v;
        knn_out_t    res;
        begin
            v = (it.bin_value > ONE_Q16) ? ONE_Q16 : it.bin_value;
            res = '0;
            case (action_t'(it.action))
                ACT_CLEAR:
                begin
                    entry_cnt = 0;
                    res.status = ST_CLEARED;
                    pending_q.push_back(res);
                end
                ACT_TRAIN:
                begin
                    if (entry_cnt < SLOTS)
                    begin
                        train_bins[entry_cnt][it.bin_index] = v;
                        train_seen[entry_cnt][it.bin_index] = 1'b1;
                    end
                    if (it.last)
                    begin
                        if (entry_cnt >= SLOTS)
                            res.status = ST_FULL;
                        else
                        begin
                            train_lbl[entry_cnt] = it.label;
                            entry_cnt++;
                            res.status = ST_STORED;
                        end
                        pending_q.push_back(res);
                    end
                end
                ACT_QUERY:
                begin
                    query_bins[it.bin_index] = v;
                    query_seen[it.bin_index] = 1'b1;
                    if (it.last)
                    begin
                        classify_query(res);
                        pending_q.push_back(res);
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic send_item(input knn_in_t it);
        bit done;
        begin
            done = 1'b0;
            while (!done)
            begin
                @(negedge clk);
                if (!calm && $urandom_range(99) < 36)
                    sample_if.valid <= 1'b0;
                else
                begin
                    sample_if.valid <= 1'b1;
                    sample_if.data  <= it;
                    @(posedge clk);
                    while (!sample_if.ready)
                        @(posedge clk);
                    predict_item(it);
                    items_sent++;
                    done = 1'b1;
                end
            end
        end
    endtask

    task automatic drop_valid();
        @(negedge clk);
        sample_if.valid <= 1'b0;
    endtask

    function automatic logic [16:0] pick_value();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'($urandom_range(65537, 131071));
            3, 4, 5: return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(30000, 30003));
        endcase
    endfunction

    function automatic knn_in_t make_item(action_t act, int idx, logic [16:0] v,
                                          logic lbl, logic lst);
        knn_in_t it;
        it.action    = act;
        it.bin_index = idx[3:0];
        it.bin_value = v;
        it.label     = lbl;
        it.last      = lst;
        return it;
    endfunction

    // Fill every bin of a fresh slot or query; reuse may write only a few.
    task automatic send_vector(input action_t act, input logic lbl, input bit fixed,
                               input logic [16:0] fixed_val);
        int  order [BINS];
        int  cnt, k, t;
        bit  whole;
        begin
            if (act == ACT_QUERY)
                whole = (query_seen != 16'hffff);
            else
                whole = (entry_cnt < SLOTS) && (train_seen[entry_cnt] != 16'hffff);
            whole = whole || fixed;
            for (int i = 0; i < BINS; i++)
                order[i] = i;
            for (int i = BINS - 1; i > 0; i--)
            begin
                k = $urandom_range(i);
                t = order[i]; order[i] = order[k]; order[k] = t;
            end
            cnt = whole ? BINS : $urandom_range(1, BINS);
            for (int i = 0; i < cnt; i++)
                send_item(make_item(act, order[i], fixed ? fixed_val : pick_value(),
                                    lbl, i == cnt - 1));
        end
    endtask

    task automatic test_empty_store();
        send_item(make_item(ACT_CLEAR, 0, 17'd0, 1'b0, 1'b0));
        send_vector(ACT_QUERY, 1'b1, 1'b1, ONE_Q16);
        send_item(make_item(ACT_NONE, 15, 17'h1ffff, 1'b1, 1'b1));
        send_item(make_item(ACT_NONE, 0, 17'd0, 1'b0, 1'b0));
    endtask

    task automatic test_few_entries();
        send_vector(ACT_TRAIN, 1'b1, 1'b1, 17'h1ffff);
        send_item(make_item(ACT_QUERY, 3, 17'd0, 1'b0, 1'b1));
        send_vector(ACT_TRAIN, 1'b0, 1'b1, 17'd0);
        send_item(make_item(ACT_QUERY, 7, ONE_Q16, 1'b1, 1'b1));
    endtask

    // Equal distances: the earlier entry must win the selection.
    task automatic test_ties();
        send_item(make_item(ACT_CLEAR, 9, 17'd5, 1'b1, 1'b1));
        send_vector(ACT_TRAIN, 1'b1, 1'b1, 17'd100);
        send_vector(ACT_TRAIN, 1'b0, 1'b1, 17'd100);
        send_vector(ACT_TRAIN, 1'b0, 1'b1, 17'd100);
        send_vector(ACT_TRAIN, 1'b1, 1'b1, 17'd100);
        send_vector(ACT_QUERY, 1'b0, 1'b1, 17'd100);
    endtask

    // Fill with one-bin entries; no query reads them before the clear.
    task automatic test_store_full();
        calm = 1'b1;
        send_item(make_item(ACT_CLEAR, 0, 17'd0, 1'b0, 1'b0));
        while (entry_cnt < SLOTS)
            send_item(make_item(ACT_TRAIN, $urandom_range(15), pick_value(),
                                1'($urandom_range(1)), 1'b1));
        send_vector(ACT_TRAIN, 1'b1, 1'b1, 17'd42);
        send_item(make_item(ACT_CLEAR, 0, 17'd0, 1'b0, 1'b1));
        calm = 1'b0;
    endtask

    // Block the receiver while results keep coming so the input backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(make_item(ACT_CLEAR, 0, 17'd0, 1'b0, 1'b0));
        for (int i = 0; i < 6; i++)
            send_vector(ACT_TRAIN, 1'($urandom_range(1)), 1'b0, 17'd0);
        send_vector(ACT_QUERY, 1'b0, 1'b0, 17'd0);
    endtask

    task automatic test_random();
        int start;
        int pick;
        begin
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS)
            begin
                calm = (items_sent - start > 250) && (items_sent - start < 400);
                pick = $urandom_range(99);
                if (entry_cnt > 24 && pick < 15)
                    send_item(make_item(ACT_CLEAR, 0, 17'd0, 1'b0, 1'($urandom_range(1))));
                else if (pick < 50)
                    send_vector(ACT_TRAIN, 1'($urandom_range(1)), 1'b0, 17'd0);
                else if (pick < 85)
                    send_vector(ACT_QUERY, 1'($urandom_range(1)), 1'b0, 17'd0);
                else if (pick < 92)
                    send_item(make_item(ACT_CLEAR, $urandom_range(15), pick_value(),
                                        1'($urandom_range(1)), 1'($urandom_range(1))));
                else
                    send_item(make_item(ACT_NONE, $urandom_range(15), pick_value(),
                                        1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            calm = 1'b0;
        end
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        knn_out_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result status=%0d", result_if.data.status);
                error_cnt++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (result_if.data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status,
                           result_if.data.status);
                    error_cnt++;
                end
                if (result_if.data.prediction !== want.prediction)
                begin
                    $error("prediction: expected %0d, got %0d", want.prediction,
                           result_if.data.prediction);
                    error_cnt++;
                end
                if (result_if.data.vote_count !== want.vote_count)
                begin
                    $error("vote_count: expected %0d, got %0d", want.vote_count,
                           result_if.data.vote_count);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            idle_cnt <= 0;
        else if (idle_cnt >= STALL_LIMIT)
        begin
            $display("[knn_majority_classifier] ERROR");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.data  = '0;
        entry_cnt  = 0;
        query_seen = '0;
        error_cnt  = 0;
        items_sent = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        idle_cnt   = 0;
        for (int e = 0; e < SLOTS; e++)
            train_seen[e] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_few_entries();
        test_ties();
        test_backpressure();
        test_store_full();
        test_random();
        drop_valid();

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_cnt == 0)
            $display("[knn_majority_classifier] OK");
        else
            $display("[knn_majority_classifier] ERROR");
        $finish;
    end
endmodule
